// ----- rtl/grid_maze_generator_defines.svh -----
// assertion macros for the grid maze generator
`ifndef GRID_MAZE_GENERATOR_DEFINES_SVH
`define GRID_MAZE_GENERATOR_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define GMG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define GMG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gmg_pkg.sv -----
// shared types, constants and functions of the grid maze generator
`default_nettype none

package gmg_pkg;

	// grid and stack sizes
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int STACK_DEPTH = 1024;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int CELLS   = MAX_ROWS * MAX_COLS;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int SADDR_W = $clog2(STACK_DEPTH);
	localparam int SP_W    = $clog2(STACK_DEPTH + 1);

	// fixed field widths
	localparam int FIELD_W    = 6;
	localparam int CFG_DIM_W  = 7;
	localparam int SEED_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// width wide enough for both configured sizes and grid limits
	localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int LIM_W   = $clog2(MAX_DIM + 1);
	localparam int DIM_W   = (LIM_W > CFG_DIM_W) ? LIM_W : CFG_DIM_W;

	localparam logic [CFG_DIM_W-1:0] ROWS_RESET = CFG_DIM_W'(63);
	localparam logic [CFG_DIM_W-1:0] COLS_RESET = CFG_DIM_W'(63);
	localparam logic [SEED_W-1:0]    SEED_RESET = SEED_W'(1);
	localparam logic [SEED_W-1:0]    LFSR_TAPS  = 32'h8020_0003;

	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_DONE = SLOT_W'(4);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_SEED = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_GENERATE = 1'b0,
		OP_READ     = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_S = 2'd1,
		DIR_E = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_RD,
		ST_STEP,
		ST_CHECK,
		ST_ENTER,
		ST_POP,
		ST_DONE
	} state_t;

	// one backtracking frame
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
	} frame_t;

	typedef struct packed {
		logic [3:0][1:0]    order;
		logic [SEED_W-1:0]  lfsr;
	} shuffle_t;

	// galois lfsr, shift right
	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] x);
		return (x >> 1) ^ (x[0] ? LFSR_TAPS : '0);
	endfunction

	// four swaps of the direction order, one lfsr step before each
	function automatic shuffle_t shuffle(input logic [3:0][1:0] order,
			input logic [SEED_W-1:0] lfsr);
		shuffle_t s;
		logic [1:0] r;
		logic [1:0] t;
		s.order = order;
		s.lfsr  = lfsr;
		for (int i = 0; i < 4; i++) begin
			s.lfsr = lfsr_step(s.lfsr);
			r = s.lfsr[1:0];
			t = s.order[r];
			s.order[r] = s.order[i];
			s.order[i] = t;
		end
		return s;
	endfunction

	// cell (r,c) lives at r*MAX_COLS+c
	function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return CELL_AW'(int'(row) * MAX_COLS + int'(col));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gmg_cmd_if.sv -----
// command channel: operation and cell coordinate
`default_nettype none

interface gmg_cmd_if;
	import gmg_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [FIELD_W-1:0] cell_row;
	logic [FIELD_W-1:0] cell_col;

	modport source (output valid, output operation, output cell_row, output cell_col,
		input ready);
	modport sink (input valid, input operation, input cell_row, input cell_col,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/gmg_res_if.sv -----
// result channel: wall flag and coordinate error flag
`default_nettype none

interface gmg_res_if;
	import gmg_pkg::*;

	logic valid;
	logic ready;
	logic is_wall;
	logic bad_coordinate;

	modport source (output valid, output is_wall, output bad_coordinate, input ready);
	modport sink (input valid, input is_wall, input bad_coordinate, output ready);
endinterface

`default_nettype wire

// ----- rtl/grid_maze_generator.sv -----
// grid maze generator top level: cell memory, frame stack and carving sequencer
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+------------------
//   cmd      | in  | operation, cell_row, cell_col    | valid / ready
//   res      | out | is_wall, bad_coordinate          | valid / ready
//   wr_*     | in  | wr_index, wr_data                | wr_en, no wait
//
// a read item goes from memory read to result register, then is loaded into the output.
// a generate item fills all MAX_ROWS*MAX_COLS cells, then per direction tried passes
// ST_STEP alone (off grid), then ST_CHECK (target open), then ST_ENTER (carved),
// plus ST_POP per pop; the registered cell memory read sets that walk.
// after reset a fill pass writes walls; no item is taken meanwhile.
// items are taken one at a time; the result waits in an output register.
`default_nettype none

`include "grid_maze_generator_defines.svh"

module grid_maze_generator (
	input  wire                            clk,
	input  wire                            arst_n,
	gmg_cmd_if.sink                        cmd,
	gmg_res_if.source                      res,
	input  wire                            wr_en,
	input  wire [gmg_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire [gmg_pkg::CFG_DATA_W-1:0]  wr_data
);
	import gmg_pkg::*;

	state_t state_q, state_d;

	logic [CFG_DIM_W-1:0] rows_q, cols_q;
	logic [SEED_W-1:0]    seed_q;
	logic [SEED_W-1:0]    lfsr_q;
	logic [3:0][1:0]      dir_q;
	logic [SP_W-1:0]      sp_q;
	logic [CELL_AW-1:0]   fill_q;
	logic                 gen_q;

	frame_t               top_q;
	logic [ROW_W-1:0]     ch_row_q, mid_row_q;
	logic [COL_W-1:0]     ch_col_q, mid_col_q;
	logic                 bad_q, res_wall_q, res_bad_q;
	logic                 out_vld_q, out_wall_q, out_bad_q;

	// memories
	logic                 maze_mem [CELLS];
	logic                 maze_rd_q;
	logic                 maze_we, maze_wdata;
	logic [CELL_AW-1:0]   maze_waddr, maze_raddr;
	frame_t               stk_mem [STACK_DEPTH];
	frame_t               stk_rd_q;
	logic                 stk_we;
	logic [SADDR_W-1:0]   stk_waddr, stk_raddr;

	logic [DIM_W-1:0]     lim_rows, lim_cols;
	logic                 cmd_acc, out_free, last_fill, slot_done, off_grid, read_bad;
	logic signed [1:0]    dy, dx;
	logic signed [DIM_W:0] nr_s, nc_s;
	shuffle_t             shuf;

	// grid limits from configuration
	always_comb begin
		if (rows_q == '0)
			lim_rows = DIM_W'(1);
		else if (DIM_W'(rows_q) > DIM_W'(MAX_ROWS))
			lim_rows = DIM_W'(MAX_ROWS);
		else
			lim_rows = DIM_W'(rows_q);
		if (cols_q == '0)
			lim_cols = DIM_W'(1);
		else if (DIM_W'(cols_q) > DIM_W'(MAX_COLS))
			lim_cols = DIM_W'(MAX_COLS);
		else
			lim_cols = DIM_W'(cols_q);
	end

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !out_vld_q || res.ready;
	assign last_fill = (fill_q == CELL_AW'(CELLS - 1));
	assign slot_done = (top_q.slot >= SLOT_DONE);
	assign read_bad  = (DIM_W'(cmd.cell_row) >= lim_rows) ||
		(DIM_W'(cmd.cell_col) >= lim_cols);
	assign shuf      = shuffle(dir_q, lfsr_q);

	// step offsets of the current direction slot
	always_comb begin
		dy = 2'sd0;
		dx = 2'sd0;
		unique case (dir_t'(dir_q[top_q.slot[1:0]]))
			DIR_N: dy = -2'sd1;
			DIR_S: dy = 2'sd1;
			DIR_E: dx = 2'sd1;
			DIR_W: dx = -2'sd1;
			default: dx = -2'sd1;
		endcase
	end

	// two-cell jump target and grid check
	always_comb begin
		nr_s = $signed({1'b0, DIM_W'(top_q.row)}) + (DIM_W+1)'(dy) + (DIM_W+1)'(dy);
		nc_s = $signed({1'b0, DIM_W'(top_q.col)}) + (DIM_W+1)'(dx) + (DIM_W+1)'(dx);
		off_grid = nr_s[DIM_W] || nc_s[DIM_W] ||
			(nr_s[DIM_W-1:0] >= lim_rows) || (nc_s[DIM_W-1:0] >= lim_cols);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL:  if (last_fill) state_d = gen_q ? ST_ENTER : ST_IDLE;
			ST_IDLE: begin
				if (cmd_acc)
					state_d = (cmd.operation == OP_READ) ? ST_RD : ST_FILL;
			end
			ST_RD:    state_d = ST_DONE;
			ST_STEP: begin
				if (slot_done)
					state_d = (sp_q == SP_W'(1)) ? ST_DONE : ST_POP;
				else if (!off_grid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (maze_rd_q && sp_q < SP_W'(STACK_DEPTH))
					state_d = ST_ENTER;
				else
					state_d = ST_STEP;
			end
			ST_ENTER: state_d = ST_STEP;
			ST_POP:   state_d = ST_STEP;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory ports and handshake
	always_comb begin
		cmd.ready  = (state_q == ST_IDLE);
		maze_we    = 1'b0;
		maze_wdata = 1'b0;
		maze_waddr = fill_q;
		maze_raddr = cell_addr(ROW_W'(nr_s[DIM_W-1:0]), COL_W'(nc_s[DIM_W-1:0]));
		stk_we     = 1'b0;
		stk_waddr  = SADDR_W'(sp_q - SP_W'(1));
		stk_raddr  = SADDR_W'(sp_q - SP_W'(2));
		unique case (state_q)
			ST_FILL: begin
				maze_we    = 1'b1;
				maze_wdata = 1'b1;
			end
			ST_IDLE: maze_raddr = cell_addr(ROW_W'(cmd.cell_row), COL_W'(cmd.cell_col));
			ST_CHECK: begin
				maze_we    = maze_rd_q && sp_q < SP_W'(STACK_DEPTH);
				maze_waddr = cell_addr(mid_row_q, mid_col_q);
			end
			ST_ENTER: begin
				maze_we    = 1'b1;
				maze_waddr = cell_addr(ch_row_q, ch_col_q);
				stk_we     = (sp_q != '0);
			end
			default: ;
		endcase
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (maze_we)
			maze_mem[maze_waddr] <= maze_wdata;
		maze_rd_q <= maze_mem[maze_raddr];
	end

	// frame stack below the top frame
	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= top_q;
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			rows_q    <= ROWS_RESET;
			cols_q    <= COLS_RESET;
			seed_q    <= SEED_RESET;
			lfsr_q    <= SEED_W'(1);
			dir_q     <= {DIR_W, DIR_E, DIR_S, DIR_N};
			sp_q      <= '0;
			fill_q    <= '0;
			gen_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// configuration writes
			if (wr_en) begin
				if (wr_index == REG_ROWS)
					rows_q <= wr_data[CFG_DIM_W-1:0];
				else if (wr_index == REG_COLS)
					cols_q <= wr_data[CFG_DIM_W-1:0];
				else if (wr_index == REG_SEED)
					seed_q <= wr_data[SEED_W-1:0];
			end
			if (state_q == ST_IDLE && cmd_acc && cmd.operation == OP_GENERATE) begin
				lfsr_q <= (seed_q != '0) ? seed_q : SEED_W'(1);
				fill_q <= '0;
				gen_q  <= 1'b1;
				sp_q   <= '0;
			end
			if (state_q == ST_FILL)
				fill_q <= fill_q + CELL_AW'(1);
			if (state_q == ST_ENTER) begin
				lfsr_q <= shuf.lfsr;
				dir_q  <= shuf.order;
				sp_q   <= sp_q + SP_W'(1);
			end
			if (state_q == ST_STEP && slot_done)
				sp_q <= sp_q - SP_W'(1);
			if (state_q == ST_DONE) begin
				gen_q <= 1'b0;
			end
			// output register
			if (state_q == ST_DONE && out_free)
				out_vld_q <= 1'b1;
			else if (res.ready)
				out_vld_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_acc)
			bad_q <= read_bad;
		if (state_q == ST_FILL && last_fill) begin
			ch_row_q <= '0;
			ch_col_q <= '0;
		end
		if (state_q == ST_STEP && !slot_done) begin
			top_q.slot <= top_q.slot + SLOT_W'(1);
			ch_row_q   <= ROW_W'(nr_s[DIM_W-1:0]);
			ch_col_q   <= COL_W'(nc_s[DIM_W-1:0]);
			mid_row_q  <= top_q.row + ROW_W'(dy);
			mid_col_q  <= top_q.col + COL_W'(dx);
		end
		if (state_q == ST_STEP && slot_done) begin
			res_wall_q <= 1'b0;
			res_bad_q  <= 1'b0;
		end
		if (state_q == ST_ENTER)
			top_q <= '{row: ch_row_q, col: ch_col_q, slot: '0};
		if (state_q == ST_POP)
			top_q <= stk_rd_q;
		if (state_q == ST_RD) begin
			res_wall_q <= bad_q | maze_rd_q;
			res_bad_q  <= bad_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_wall_q <= res_wall_q;
			out_bad_q  <= res_bad_q;
		end
	end

	assign res.valid          = out_vld_q;
	assign res.is_wall        = out_wall_q;
	assign res.bad_coordinate = out_bad_q;

	// checks
	`GMG_ASSERT_IMP(a_idle_stack_empty, state_q == ST_IDLE, sp_q == '0, "stack not empty at idle")
	`GMG_ASSERT_IMP(a_carve_only_wall, state_q == ST_CHECK && maze_we, maze_rd_q, "carved open cell")
	`GMG_ASSERT_NEXT(a_push_grows, state_q == ST_ENTER, sp_q == $past(sp_q) + SP_W'(1), "push lost")
	`GMG_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= SP_W'(STACK_DEPTH), "stack pointer overflow")

endmodule

`default_nettype wire

// ----- tb/sv/grid_maze_generator_test.sv -----
// self-checking testbench of the grid maze generator: predicted cells against read items
`default_nettype none

module grid_maze_generator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gmg_pkg::*;

	// slowest run: ~30 generates and 1100 items, slowed by receiver stalls and sender
	// gaps, then several times that
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int ITEM_TARGET = 1100;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic is_wall;
		logic bad_coordinate;
	} cell_report_t;

	// maze predictor and store of expected reports
	class maze_checker;
		bit                   cells [MAX_ROWS][MAX_COLS];
		dir_t                 dir_order [4];
		logic [SEED_W-1:0]    lfsr;
		logic [CFG_DIM_W-1:0] rows_cfg;
		logic [CFG_DIM_W-1:0] cols_cfg;
		logic [SEED_W-1:0]    seed_cfg;
		int                   frame_row [STACK_DEPTH];
		int                   frame_col [STACK_DEPTH];
		int                   frame_slot [STACK_DEPTH];
		int                   depth;
		cell_report_t         expected_reports [$];
		int                   mismatches;
		int                   reports_seen;

		function new();
			rows_cfg = ROWS_RESET;
			cols_cfg = COLS_RESET;
			seed_cfg = SEED_RESET;
			lfsr = 1;
			dir_order = '{DIR_N, DIR_S, DIR_E, DIR_W};
			foreach (cells[r, c]) cells[r][c] = 1'b1;
			depth = 0;
			mismatches = 0;
			reports_seen = 0;
		endfunction

		function void note_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ROWS: rows_cfg = data[CFG_DIM_W-1:0];
				REG_COLS: cols_cfg = data[CFG_DIM_W-1:0];
				REG_SEED: seed_cfg = data[SEED_W-1:0];
				default: ;
			endcase
		endfunction

		// zero counts as one, anything past the grid saturates
		function int clamp_dim(logic [CFG_DIM_W-1:0] v, int limit);
			if (v == 0)
				return 1;
			if (int'(v) > limit)
				return limit;
			return int'(v);
		endfunction

		function int grid_rows();
			return clamp_dim(rows_cfg, MAX_ROWS);
		endfunction

		function int grid_cols();
			return clamp_dim(cols_cfg, MAX_COLS);
		endfunction

		// four swaps, lfsr stepped before each, low two bits pick the partner
		function void shuffle_order();
			int   r;
			dir_t t;
			for (int i = 0; i < 4; i++) begin
				lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
				r = int'(lfsr[1:0]);
				t = dir_order[r];
				dir_order[r] = dir_order[i];
				dir_order[i] = t;
			end
		endfunction

		function void open_and_push(int row, int col);
			if (depth >= STACK_DEPTH)
				return;
			cells[row][col] = 1'b0;
			shuffle_order();
			frame_row[depth] = row;
			frame_col[depth] = col;
			frame_slot[depth] = 0;
			depth++;
		endfunction

		// depth-first carve from the corner, two cells per step
		function void carve_maze();
			int rows;
			int cols;
			int row;
			int col;
			int slot;
			int dy;
			int dx;
			int nr;
			int nc;
			rows = grid_rows();
			cols = grid_cols();
			foreach (cells[r, c]) cells[r][c] = 1'b1;
			lfsr = (seed_cfg == 0) ? SEED_W'(1) : seed_cfg;
			depth = 0;
			open_and_push(0, 0);
			while (depth > 0) begin
				row = frame_row[depth-1];
				col = frame_col[depth-1];
				slot = frame_slot[depth-1];
				if (slot >= 4) begin
					depth--;
					continue;
				end
				frame_slot[depth-1] = slot + 1;
				dy = 0;
				dx = 0;
				case (dir_order[slot])
					DIR_N: dy = -1;
					DIR_S: dy = 1;
					DIR_E: dx = 1;
					default: dx = -1;
				endcase
				nr = row + 2 * dy;
				nc = col + 2 * dx;
				if (nr < 0 || nr >= rows || nc < 0 || nc >= cols)
					continue;
				if (!cells[nr][nc])
					continue;
				if (depth >= STACK_DEPTH)
					continue;
				cells[row+dy][col+dx] = 1'b0;
				open_and_push(nr, nc);
			end
		endfunction

		function void note_command(op_t op, logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col);
			cell_report_t rep;
			rep.is_wall = 1'b0;
			rep.bad_coordinate = 1'b0;
			if (op == OP_GENERATE) begin
				carve_maze();
			end else if (int'(row) >= grid_rows() || int'(col) >= grid_cols()) begin
				rep.is_wall = 1'b1;
				rep.bad_coordinate = 1'b1;
			end else begin
				rep.is_wall = cells[row][col];
			end
			expected_reports.push_back(rep);
		endfunction

		function void check_result(logic is_wall, logic bad_coordinate);
			cell_report_t want;
			reports_seen++;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("result with none expected: is_wall %b bad_coordinate %b",
						is_wall, bad_coordinate);
				return;
			end
			want = expected_reports.pop_front();
			if (want.is_wall !== is_wall || want.bad_coordinate !== bad_coordinate) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("result %0d: is_wall exp %b got %b, bad_coordinate exp %b got %b",
						reports_seen, want.is_wall, is_wall, want.bad_coordinate,
						bad_coordinate);
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	gmg_cmd_if cmd_ch();
	gmg_res_if res_ch();

	maze_checker board = new();

	int unsigned send_gap = 0;
	bit          steady_phase = 1'b0;
	int          items_sent = 0;
	int          cycle_count = 0;

	grid_maze_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("TEST FAILED");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_result(res_ch.is_wall, res_ch.bad_coordinate);
	end

	// receiver: short and long stalls, calm stretches, one long hold-off
	initial begin
		int  hold_left;
		int  calm_left;
		int  pick;
		bit  hold_done;
		hold_left = 0;
		calm_left = 0;
		hold_done = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && !hold_done && board.reports_seen >= 40) begin
				hold_left = 600;
				hold_done = 1'b1;
			end else if (hold_left == 0) begin
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 3)
						calm_left = $urandom_range(50, 300);
					else if (pick < 6)
						hold_left = $urandom_range(20, 80);
					else if (pick < 35)
						hold_left = $urandom_range(1, 3);
				end
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady_phase || pick < 40)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one item and wait for it to be taken
	task automatic send_item(op_t op, logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col,
			bit last);
		if (send_gap > 0)
			repeat (send_gap) @(posedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.cell_row <= row;
		cmd_ch.cell_col <= col;
		do @(posedge clk); while (!cmd_ch.ready);
		board.note_command(op, row, col);
		items_sent++;
		send_gap = pick_gap();
		if (last || send_gap > 0)
			cmd_ch.valid <= 1'b0;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		board.note_config(idx, data);
	endtask

	// selected registers back to back, then the write enable drops
	task automatic configure(logic [CFG_DIM_W-1:0] rows, logic [CFG_DIM_W-1:0] cols,
			logic [SEED_W-1:0] seed, logic [2:0] which);
		if (which[0])
			write_reg(REG_ROWS, CFG_DATA_W'(rows));
		if (which[1])
			write_reg(REG_COLS, CFG_DATA_W'(cols));
		if (which[2])
			write_reg(REG_SEED, CFG_DATA_W'(seed));
		wr_en <= 1'b0;
	endtask

	// every expected result in, then a settling margin
	task automatic drain();
		while (board.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// reads mostly inside the grid, the rest anywhere
	task automatic random_reads(int count);
		logic [FIELD_W-1:0] row;
		logic [FIELD_W-1:0] col;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 80) begin
				row = FIELD_W'($urandom_range(0, board.grid_rows() - 1));
				col = FIELD_W'($urandom_range(0, board.grid_cols() - 1));
			end else begin
				row = FIELD_W'($urandom_range(0, 63));
				col = FIELD_W'($urandom_range(0, 63));
			end
			send_item(OP_READ, row, col, k == count - 1);
		end
	endtask

	// stimulus
	initial begin
		int                   pick;
		int                   gens;
		logic [CFG_DIM_W-1:0] rows;
		logic [CFG_DIM_W-1:0] cols;
		logic [SEED_W-1:0]    seed;
		logic [2:0]           which;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_ROWS;
		wr_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_GENERATE;
		cmd_ch.cell_row <= '0;
		cmd_ch.cell_col <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes of 63 by 63: all walls before any generate, then a maze
		send_item(OP_READ, 6'd0, 6'd0, 1'b0);
		send_item(OP_READ, 6'd63, 6'd63, 1'b0);
		send_item(OP_GENERATE, 6'd63, 6'd63, 1'b0);
		send_item(OP_READ, 6'd0, 6'd0, 1'b0);
		send_item(OP_READ, 6'd62, 6'd62, 1'b0);
		send_item(OP_READ, 6'd0, 6'd63, 1'b1);
		drain();

		// zero sizes count as one, zero seed loads as one
		configure(7'd0, 7'd0, 32'd0, 3'b111);
		send_item(OP_GENERATE, 6'd0, 6'd0, 1'b0);
		send_item(OP_READ, 6'd0, 6'd0, 1'b0);
		send_item(OP_READ, 6'd0, 6'd1, 1'b0);
		send_item(OP_READ, 6'd1, 6'd0, 1'b1);
		drain();

		// oversized rows saturate, full grid, all-ones seed
		configure(7'd127, 7'd64, 32'hFFFF_FFFF, 3'b111);
		send_item(OP_GENERATE, 6'd42, 6'd21, 1'b0);
		send_item(OP_READ, 6'd63, 6'd63, 1'b0);
		send_item(OP_READ, 6'd63, 6'd62, 1'b0);
		send_item(OP_READ, 6'd1, 6'd1, 1'b0);
		send_item(OP_READ, 6'd62, 6'd63, 1'b1);
		drain();

		// single row, then single column
		configure(7'd1, 7'd64, $urandom, 3'b111);
		send_item(OP_GENERATE, 6'd0, 6'd0, 1'b0);
		send_item(OP_READ, 6'd0, 6'd63, 1'b0);
		send_item(OP_READ, 6'd1, 6'd62, 1'b1);
		drain();
		configure(7'd64, 7'd1, $urandom, 3'b111);
		send_item(OP_GENERATE, 6'd0, 6'd0, 1'b0);
		send_item(OP_READ, 6'd62, 6'd0, 1'b0);
		send_item(OP_READ, 6'd63, 6'd1, 1'b1);
		drain();

		// small maze, then larger sizes without a generate: outside cells stay walls
		configure(7'd2, 7'd3, $urandom, 3'b111);
		send_item(OP_GENERATE, 6'd0, 6'd0, 1'b1);
		drain();
		configure(7'd64, 7'd64, 32'd0, 3'b011);
		send_item(OP_READ, 6'd0, 6'd1, 1'b0);
		send_item(OP_READ, 6'd1, 6'd1, 1'b0);
		send_item(OP_READ, 6'd40, 6'd40, 1'b1);

		// random phases: new settings, zero to two generates, then reads over the grid
		while (items_sent < ITEM_TARGET) begin
			drain();
			steady_phase = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				rows = CFG_DIM_W'($urandom_range(48, 127));
				cols = CFG_DIM_W'($urandom_range(48, 127));
			end else if (pick < 23) begin
				rows = CFG_DIM_W'($urandom_range(0, 3));
				cols = CFG_DIM_W'($urandom_range(40, 127));
				if (pick < 15) begin
					cols = rows;
					rows = CFG_DIM_W'($urandom_range(40, 127));
				end
			end else begin
				rows = CFG_DIM_W'($urandom_range(0, 16));
				cols = CFG_DIM_W'($urandom_range(0, 16));
			end
			pick = $urandom_range(0, 99);
			if (pick < 5)
				seed = '0;
			else if (pick < 10)
				seed = '1;
			else
				seed = $urandom;
			which = ($urandom_range(0, 99) < 80) ? 3'b111 : 3'($urandom_range(0, 7));
			configure(rows, cols, seed, which);
			pick = $urandom_range(0, 99);
			gens = (pick < 8) ? 0 : (pick < 14) ? 2 : 1;
			for (int g = 0; g < gens; g++)
				send_item(OP_GENERATE, 6'($urandom), 6'($urandom), 1'b0);
			random_reads($urandom_range(20, 60));
		end

		// wind down
		drain();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/gmg_pkg.sv
rtl/gmg_cmd_if.sv
rtl/gmg_res_if.sv
rtl/grid_maze_generator.sv
tb/sv/grid_maze_generator_test.sv
